>>> src/dqs_pkg.sv
// Package for the deque with key search.
// Holds the field widths, request mode codes and sequencer state type.
// No dependencies.
package dqs_pkg;

  localparam int MODE_W     = 3;
  localparam int PROC_ID_W  = 16;
  localparam int PAYLOAD_W  = 32;
  localparam int POSITION_W = 5;
  localparam int COUNT_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_POS   = 3'd4,
    MODE_FIND_ID    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FIND,
    ST_DONE
  } state_t;

endpackage

>>> src/dqs_if.sv
// Request and result channel interfaces of the deque with key search.
// Depends on dqs_pkg for the field widths.
interface dqs_in_if;
  logic                                valid;
  logic                                ready;
  logic [dqs_pkg::MODE_W-1:0]          mode;
  logic [dqs_pkg::PROC_ID_W-1:0]       proc_id;
  logic [dqs_pkg::PAYLOAD_W-1:0]       payload;
  logic [dqs_pkg::POSITION_W-1:0]      position;

  modport source (output valid, mode, proc_id, payload, position, input ready);
  modport sink   (input valid, mode, proc_id, payload, position, output ready);
endinterface

interface dqs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [dqs_pkg::PROC_ID_W-1:0]       found_id;
  logic [dqs_pkg::PAYLOAD_W-1:0]       found_payload;
  logic [dqs_pkg::COUNT_W-1:0]         count;
  logic                                is_empty;

  modport source (output valid, ok, found_id, found_payload, count, is_empty, input ready);
  modport sink   (input valid, ok, found_id, found_payload, count, is_empty, output ready);
endinterface

>>> src/dqs_ring.sv
// Shared ring index unit: (base + offset) mod DEPTH, offset below DEPTH.
// Used for every slot and head pointer computation. No dependencies.
module dqs_ring #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] idx
);
  localparam int AW = $clog2(DEPTH);

  logic [AW:0] sum;

  assign sum = {1'b0, base} + {1'b0, offset};

  always_comb begin
    if (sum >= (AW+1)'(DEPTH)) begin
      idx = AW'(sum - (AW+1)'(DEPTH));
    end else begin
      idx = AW'(sum);
    end
  end
endmodule

>>> src/dqs_mem.sv
// Entry store: one port, write or registered read at one address per cycle.
// Contents are undefined until written. No dependencies.
module dqs_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> src/dqs_ctrl.sv
// Sequencer of the deque: head and count registers, request decode,
// one-entry-per-cycle id scan, result and output registers.
// Depends on dqs_pkg and dqs_if; drives dqs_ring and dqs_mem from the top.
module dqs_ctrl #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int ID_BITS      = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dqs_in_if.sink                      in_req,
  dqs_out_if.source                   out_rsp,
  output logic [$clog2(DEPTH)-1:0]    ring_base,
  output logic [$clog2(DEPTH)-1:0]    ring_off,
  input  logic [$clog2(DEPTH)-1:0]    ring_idx,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [ID_BITS+PAYLOAD_BITS-1:0] mem_wdata,
  input  logic [ID_BITS+PAYLOAD_BITS-1:0] mem_rdata
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  dqs_pkg::state_t                 state_r, state_nxt;
  logic [dqs_pkg::MODE_W-1:0]      mode_r, mode_nxt;
  logic [ID_BITS-1:0]              key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0]         pay_r, pay_nxt;
  logic [dqs_pkg::POSITION_W-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]                   head_r, head_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   i_r, i_nxt;
  logic                            cmp_v_r, cmp_v_nxt;
  logic                            res_ok_r, res_ok_nxt;
  logic [ID_BITS-1:0]              res_id_r, res_id_nxt;
  logic [PAYLOAD_BITS-1:0]         res_pay_r, res_pay_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [dqs_pkg::PROC_ID_W-1:0]   out_id_r, out_id_nxt;
  logic [dqs_pkg::PAYLOAD_W-1:0]   out_pay_r, out_pay_nxt;
  logic [dqs_pkg::COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                            out_empty_r, out_empty_nxt;

  logic [ID_BITS-1:0]              rd_id;
  logic [PAYLOAD_BITS-1:0]         rd_pay;
  logic                            not_full;
  logic                            not_empty;
  logic                            pos_ok;

  assign rd_id     = mem_rdata[ID_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
  assign rd_pay    = mem_rdata[PAYLOAD_BITS-1:0];
  assign not_full  = count_r < CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign pos_ok    = (pos_r != '0) && (32'(pos_r) <= 32'(count_r));
  assign ring_base = head_r;
  assign mem_wdata = {key_r, pay_r};

  assign in_req.ready          = state_r == dqs_pkg::ST_IDLE;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.ok            = out_ok_r;
  assign out_rsp.found_id      = out_id_r;
  assign out_rsp.found_payload = out_pay_r;
  assign out_rsp.count         = out_count_r;
  assign out_rsp.is_empty      = out_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqs_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      i_r         <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    pay_r       <= pay_nxt;
    pos_r       <= pos_nxt;
    res_ok_r    <= res_ok_nxt;
    res_id_r    <= res_id_nxt;
    res_pay_r   <= res_pay_nxt;
    out_ok_r    <= out_ok_nxt;
    out_id_r    <= out_id_nxt;
    out_pay_r   <= out_pay_nxt;
    out_count_r <= out_count_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    pos_nxt       = pos_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    cmp_v_nxt     = cmp_v_r;
    res_ok_nxt    = res_ok_r;
    res_id_nxt    = res_id_r;
    res_pay_nxt   = res_pay_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_id_nxt    = out_id_r;
    out_pay_nxt   = out_pay_r;
    out_count_nxt = out_count_r;
    out_empty_nxt = out_empty_r;
    ring_off      = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dqs_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          mode_nxt  = in_req.mode;
          key_nxt   = ID_BITS'(in_req.proc_id);
          pay_nxt   = PAYLOAD_BITS'(in_req.payload);
          pos_nxt   = in_req.position;
          state_nxt = dqs_pkg::ST_EXEC;
        end
      end
      dqs_pkg::ST_EXEC: begin
        res_ok_nxt  = 1'b0;
        res_id_nxt  = '0;
        res_pay_nxt = '0;
        i_nxt       = '0;
        cmp_v_nxt   = 1'b0;
        state_nxt   = dqs_pkg::ST_DONE;
        unique case (dqs_pkg::mode_t'(mode_r))
          dqs_pkg::MODE_PUSH_FRONT: begin
            ring_off = AW'(DEPTH - 1);
            if (not_full) begin
              mem_we     = 1'b1;
              head_nxt   = ring_idx;
              count_nxt  = count_r + CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          dqs_pkg::MODE_PUSH_BACK: begin
            ring_off = AW'(count_r);
            if (not_full) begin
              mem_we     = 1'b1;
              count_nxt  = count_r + CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          dqs_pkg::MODE_POP_FRONT: begin
            ring_off = AW'(1);
            if (not_empty) begin
              head_nxt   = ring_idx;
              count_nxt  = count_r - CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          dqs_pkg::MODE_POP_BACK: begin
            if (not_empty) begin
              count_nxt  = count_r - CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          dqs_pkg::MODE_READ_POS: begin
            ring_off = AW'(pos_r - dqs_pkg::POSITION_W'(1));
            if (pos_ok) begin
              mem_re    = 1'b1;
              state_nxt = dqs_pkg::ST_READ;
            end
          end
          dqs_pkg::MODE_FIND_ID: begin
            state_nxt = dqs_pkg::ST_FIND;
          end
          default: begin
          end
        endcase
      end
      dqs_pkg::ST_READ: begin
        res_ok_nxt  = 1'b1;
        res_id_nxt  = rd_id;
        res_pay_nxt = rd_pay;
        state_nxt   = dqs_pkg::ST_DONE;
      end
      dqs_pkg::ST_FIND: begin
        ring_off = AW'(i_r);
        priority if (cmp_v_r && (rd_id == key_r)) begin
          res_ok_nxt  = 1'b1;
          res_id_nxt  = rd_id;
          res_pay_nxt = rd_pay;
          cmp_v_nxt   = 1'b0;
          state_nxt   = dqs_pkg::ST_DONE;
        end else if (i_r < count_r) begin
          mem_re    = 1'b1;
          i_nxt     = i_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
          state_nxt = dqs_pkg::ST_DONE;
        end
      end
      dqs_pkg::ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_id_nxt    = dqs_pkg::PROC_ID_W'(res_id_r);
          out_pay_nxt   = dqs_pkg::PAYLOAD_W'(res_pay_r);
          out_count_nxt = dqs_pkg::COUNT_W'(count_r);
          out_empty_nxt = count_r == '0;
          state_nxt     = dqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dqs_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while busy");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> not_full)
    else $error("store written while full");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dqs_pkg::ST_DONE))
    else $error("result issued outside done state");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dqs_pkg::ST_FIND) |-> (i_r <= count_r))
    else $error("scan index beyond count");
endmodule

>>> src/double_ended_queue_with_search_top.sv
// Deque of process records with search by id, held in a single-port ring
// store of DEPTH entries. Requests are taken one at a time: push and pop
// finish in the execute state, read by position adds a read state, and find
// by id scans the one store port one entry per cycle from the front until
// the first match. A finished result waits in an output register while
// the next request is accepted.
// Depends on dqs_pkg, dqs_if, dqs_ring, dqs_mem and dqs_ctrl.
module double_ended_queue_with_search_top #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int ID_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dqs_in_if.sink     in_req,
  dqs_out_if.source  out_rsp
);
  localparam int AW = $clog2(DEPTH);
  localparam int EW = ID_BITS + PAYLOAD_BITS;

  logic [AW-1:0] ring_base;
  logic [AW-1:0] ring_off;
  logic [AW-1:0] ring_idx;
  logic          mem_we;
  logic          mem_re;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] mem_rdata;

  dqs_ring #(.DEPTH(DEPTH)) u_ring (
    .base   (ring_base),
    .offset (ring_off),
    .idx    (ring_idx)
  );

  dqs_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (ring_idx),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  dqs_ctrl #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .ID_BITS      (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .ring_base (ring_base),
    .ring_off  (ring_off),
    .ring_idx  (ring_idx),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );
endmodule

>>> tb/sv/tb_top.sv
// Testbench for double_ended_queue_with_search_top: directed and random requests,
// with a shadow deque that predicts every result and checks each field.
// Depends on dqs_pkg, dqs_if and the RTL under src.
module tb_top;

  localparam int DEPTH        = 16;
  localparam int TOTAL_ITEMS  = 1050;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [dqs_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [dqs_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                          ok;
    logic [dqs_pkg::PROC_ID_W-1:0] found_id;
    logic [dqs_pkg::PAYLOAD_W-1:0] found_payload;
    logic [dqs_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;
  } rsp_t;

  class deque_shadow;
    logic [dqs_pkg::PROC_ID_W-1:0] ids [DEPTH];
    logic [dqs_pkg::PAYLOAD_W-1:0] pays [DEPTH];
    int   head;
    int   used;
    int   errors;
    rsp_t pending_rsp [$];

    function new();
      head   = 0;
      used   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function logic [dqs_pkg::PROC_ID_W-1:0] stored_id();
      return ids[(head + $urandom_range(0, used - 1)) % DEPTH];
    endfunction

    function void note_request(logic [dqs_pkg::MODE_W-1:0] mode,
                               logic [dqs_pkg::PROC_ID_W-1:0] id,
                               logic [dqs_pkg::PAYLOAD_W-1:0] pay,
                               logic [dqs_pkg::POSITION_W-1:0] pos);
      rsp_t r;
      int   slot;
      bit   hit;
      r   = '0;
      hit = 0;
      case (mode)
        dqs_pkg::MODE_PUSH_FRONT: begin
          if (used < DEPTH) begin
            head = (head + DEPTH - 1) % DEPTH;
            ids[head]  = id;
            pays[head] = pay;
            used++;
            r.ok = 1'b1;
          end
        end
        dqs_pkg::MODE_PUSH_BACK: begin
          if (used < DEPTH) begin
            slot = (head + used) % DEPTH;
            ids[slot]  = id;
            pays[slot] = pay;
            used++;
            r.ok = 1'b1;
          end
        end
        dqs_pkg::MODE_POP_FRONT: begin
          if (used > 0) begin
            head = (head + 1) % DEPTH;
            used--;
            r.ok = 1'b1;
          end
        end
        dqs_pkg::MODE_POP_BACK: begin
          if (used > 0) begin
            used--;
            r.ok = 1'b1;
          end
        end
        dqs_pkg::MODE_READ_POS: begin
          if (pos >= 1 && pos <= used) begin
            slot = (head + pos - 1) % DEPTH;
            r.ok            = 1'b1;
            r.found_id      = ids[slot];
            r.found_payload = pays[slot];
          end
        end
        dqs_pkg::MODE_FIND_ID: begin
          for (int i = 0; i < used; i++) begin
            slot = (head + i) % DEPTH;
            if (!hit && ids[slot] == id) begin
              hit             = 1;
              r.ok            = 1'b1;
              r.found_id      = ids[slot];
              r.found_payload = pays[slot];
            end
          end
        end
        default: ;
      endcase
      r.count    = dqs_pkg::COUNT_W'(used);
      r.is_empty = (used == 0);
      pending_rsp.push_back(r);
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending_rsp.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok got %0b want %0b", got.ok, want.ok));
      if (got.found_id !== want.found_id)
        report($sformatf("found_id got %h want %h", got.found_id, want.found_id));
      if (got.found_payload !== want.found_payload)
        report($sformatf("found_payload got %h want %h", got.found_payload, want.found_payload));
      if (got.count !== want.count)
        report($sformatf("count got %0d want %0d", got.count, want.count));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycles      = 0;
  int   items_sent  = 0;
  bit   idle_enabled = 1'b1;
  bit   hold_output  = 1'b0;
  bit   filling      = 1'b1;

  deque_shadow shadow = new();

  dqs_in_if  in_req ();
  dqs_out_if out_rsp ();

  double_ended_queue_with_search_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_request(input logic [dqs_pkg::MODE_W-1:0] m,
                              input logic [dqs_pkg::PROC_ID_W-1:0] id,
                              input logic [dqs_pkg::PAYLOAD_W-1:0] pay,
                              input logic [dqs_pkg::POSITION_W-1:0] pos);
    in_req.valid    = 1'b1;
    in_req.mode     = m;
    in_req.proc_id  = id;
    in_req.payload  = pay;
    in_req.position = pos;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    shadow.note_request(m, id, pay, pos);
    items_sent++;
    if (items_sent == HOLD_AT) hold_output = 1'b1;
    idle_enabled = (items_sent < TOTAL_ITEMS - QUIET_TAIL) && ((items_sent / 60) % 4 != 3);
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_req.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic send_random();
    int                             r;
    int                             push_w;
    logic [dqs_pkg::MODE_W-1:0]     m;
    logic [dqs_pkg::PROC_ID_W-1:0]  id;
    logic [dqs_pkg::POSITION_W-1:0] pos;
    if (shadow.used == DEPTH) filling = 1'b0;
    else if (shadow.used == 0) filling = 1'b1;
    push_w = filling ? 45 : 15;
    r = $urandom_range(0, 99);
    if (r < push_w)
      m = $urandom_range(0, 1) ? dqs_pkg::MODE_PUSH_FRONT : dqs_pkg::MODE_PUSH_BACK;
    else if (r < 60)
      m = $urandom_range(0, 1) ? dqs_pkg::MODE_POP_FRONT : dqs_pkg::MODE_POP_BACK;
    else if (r < 75)
      m = dqs_pkg::MODE_READ_POS;
    else if (r < 97)
      m = dqs_pkg::MODE_FIND_ID;
    else
      m = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
    // small id pool gives duplicates, so a find must pick the frontmost match
    r = $urandom_range(0, 9);
    if (r < 4)                          id = dqs_pkg::PROC_ID_W'($urandom_range(0, 7));
    else if (r < 7 || shadow.used == 0) id = dqs_pkg::PROC_ID_W'($urandom());
    else                                id = shadow.stored_id();
    if (shadow.used > 0 && $urandom_range(0, 4) != 0)
      pos = dqs_pkg::POSITION_W'($urandom_range(1, shadow.used));
    else
      pos = dqs_pkg::POSITION_W'($urandom_range(0, DEPTH));
    send_request(m, id, $urandom(), pos);
  endtask

  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_rsp.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_output = 1'b0;
      end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
        out_rsp.ready = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_rsp.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    rsp_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[double_ended_queue_with_search_top] ERROR");
      $finish;
    end else if (rst_n === 1'b1 && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      got = '{out_rsp.ok, out_rsp.found_id, out_rsp.found_payload, out_rsp.count,
              out_rsp.is_empty};
      shadow.check_response(got);
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_req.valid    = 1'b0;
    in_req.mode     = dqs_pkg::MODE_PUSH_FRONT;
    in_req.proc_id  = '0;
    in_req.payload  = '0;
    in_req.position = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty store, unused mode
    send_request(dqs_pkg::MODE_POP_FRONT, '0, '0, '0);
    send_request(dqs_pkg::MODE_FIND_ID, 16'hFFFF, '0, '0);
    send_request(MODE_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF, 5'd16);
    // fill from both ends, repeated ids
    for (int i = 0; i < DEPTH; i++)
      send_request(i % 2 ? dqs_pkg::MODE_PUSH_BACK : dqs_pkg::MODE_PUSH_FRONT,
                   (i == 1) ? 16'h0000 : (i % 3 == 0) ? 16'hFFFF : dqs_pkg::PROC_ID_W'(i),
                   (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : $urandom(), '0);
    send_request(dqs_pkg::MODE_PUSH_FRONT, 16'h5555, 32'hA5A5_A5A5, '0);
    send_request(dqs_pkg::MODE_PUSH_BACK, 16'hAAAA, 32'h5A5A_5A5A, '0);
    send_request(dqs_pkg::MODE_READ_POS, '0, '0, 5'd16);
    send_request(dqs_pkg::MODE_READ_POS, '0, '0, 5'd0);
    send_request(dqs_pkg::MODE_FIND_ID, 16'hFFFF, '0, '0);
    send_request(dqs_pkg::MODE_FIND_ID, 16'h0000, '0, '0);
    send_request(dqs_pkg::MODE_POP_BACK, '0, '0, '0);
    send_request(dqs_pkg::MODE_POP_FRONT, '0, '0, '0);
    send_request(dqs_pkg::MODE_READ_POS, '0, '0, 5'd16);

    while (items_sent < TOTAL_ITEMS) send_random();
    in_req.valid = 1'b0;

    while (shadow.pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0)
      $display("[double_ended_queue_with_search_top] OK");
    else
      $display("[double_ended_queue_with_search_top] ERROR");
    $finish;
  end

endmodule

>>> files.f
src/dqs_pkg.sv
src/dqs_if.sv
src/dqs_ring.sv
src/dqs_mem.sv
src/dqs_ctrl.sv
src/double_ended_queue_with_search_top.sv
tb/sv/tb_top.sv
